@@ sv/piqfd_pkg.sv @@
// Package with shared types and constants for the packed I/Q float decoder.
package piqfd_pkg;

   localparam int CodeWidth  = 16;
   localparam int FloatWidth = 32;

   // Result of one decode lane: sign, magnitude (up to 13 bits) and exponent offset.
   typedef struct packed {
      logic        zero;
      logic        sign;
      logic [12:0] mag;
      logic [7:0]  base;
   } lane_type;

endpackage

@@ sv/piqfd_lane.sv @@
// One decode lane: unpacks a 16-bit code into sign, magnitude and biased exponent base.
module piqfd_lane (
   input  logic                                high_snr,
   input  logic [piqfd_pkg::CodeWidth-1:0]     code,
   output piqfd_pkg::lane_type                 lane
);

   logic [12:0] mant;
   logic        neg;
   logic [12:0] mag;
   logic [7:0]  base;
   logic        zero;

   always_comb begin
      mant = '0;
      neg  = 1'b0;
      base = '0;
      zero = 1'b0;
      if (!high_snr) begin
         zero = (code == '0);
         neg  = code[10];
         // Negative mantissa is low10 - 2048; magnitude is 2048 - low10.
         mant = neg ? (13'd2048 - {3'b000, code[9:0]}) : {3'b001, code[9:0]};
         base = 8'(8'd127 + {3'b000, code[15:11]} - 8'd40);
      end else if (code[15:12] != 4'd0) begin
         neg  = code[11];
         // The most negative mantissa has a magnitude of 4096, which needs 13 bits.
         mant = neg ? (13'd4096 - {2'b00, code[10:0]}) : {2'b01, code[10:0]};
         base = 8'(8'd127 + {4'b0000, code[15:12]} - 8'd25);
      end else begin
         zero = (code[11:0] == '0);
         neg  = code[11];
         mant = neg ? (13'd4096 - {1'b0, code[11:0]}) : {1'b0, code[11:0]};
         base = 8'd103;
      end
      mag = mant;
   end

   assign lane.zero = zero;
   assign lane.sign = neg;
   assign lane.mag  = mag;
   assign lane.base = base;

endmodule

@@ sv/piqfd_pack.sv @@
// Normalises one lane result into an IEEE single-precision bit pattern.
module piqfd_pack (
   input  piqfd_pkg::lane_type                 lane,
   output logic [piqfd_pkg::FloatWidth-1:0]    value
);

   logic [3:0]  msb;
   logic [22:0] frac;
   logic [23:0] shifted;

   always_comb begin
      msb = '0;
      for (int b = 0; b < 13; b++) begin
         if (lane.mag[b]) msb = 4'(b);
      end
      shifted = {11'd0, lane.mag} << (5'd23 - {1'b0, msb});
      frac    = shifted[22:0];
      if (lane.zero) begin
         value = '0;
      end else begin
         value = {lane.sign, 8'(lane.base + {4'd0, msb}), frac};
      end
   end

endmodule

@@ sv/packed_iq_float_decode_core.sv @@
// Top level of the packed I/Q float decoder.
// Input channel req_*: one transaction per radar gate, holding the packed I and Q
// codes in tdata and the last-gate flag in tlast. Result channel rsp_*: the two
// IEEE single-precision values in tdata and the copied flag in tlast.
// csr_*: write channel for the one-bit format register (1 = high-SNR packing).
// The I and Q codes are decoded by two identical lanes side by side and the
// merged result is held in an output register; one gate is accepted every
// cycle while req_tready is high. A skid register lets the block take a new
// transaction while the receiver stalls, so req_tready only falls when both
// the output and the skid register are full.
// Reset (synchronous, active high) empties both registers and clears the
// format register to legacy packing. The user must write the format register
// only while no transaction is in flight; the block does not enforce it.
module packed_iq_float_decode_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // i_code [15:0], q_code [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // i_value [31:0], q_value [63:32]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic                 fmt_ff, fmt_in;
   piqfd_pkg::lane_type  i_lane, q_lane;
   logic [31:0]          i_val, q_val;
   logic                 out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [64:0]          out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic                 req_fire, rsp_fire;

   piqfd_lane u_lane_i (.high_snr(fmt_ff), .code(req_tdata[15:0]),  .lane(i_lane));
   piqfd_lane u_lane_q (.high_snr(fmt_ff), .code(req_tdata[31:16]), .lane(q_lane));
   piqfd_pack u_pack_i (.lane(i_lane), .value(i_val));
   piqfd_pack u_pack_q (.lane(q_lane), .value(q_val));

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_v_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff[63:0];
   assign rsp_tlast  = out_d_ff[64];

   always_comb begin
      fmt_in    = (csr_valid && csr_ready) ? csr_data : fmt_ff;
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (rsp_fire || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
            if (req_fire) begin
               skid_v_in = 1'b1;
               skid_d_in = {req_tlast, q_val, i_val};
            end
         end else begin
            out_v_in = req_fire;
            out_d_in = {req_tlast, q_val, i_val};
         end
      end else if (req_fire) begin
         skid_v_in = 1'b1;
         skid_d_in = {req_tlast, q_val, i_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         fmt_ff    <= fmt_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   // The skid register only fills while the output register is full.
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid full while output empty");

   // A stalled result must not change underneath the receiver.
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

   // After any accepted transaction the output register holds a pending result next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> out_v_ff) else $error("accepted transaction lost");

endmodule

@@ dv/packed_iq_float_decode_core_test.sv @@
// Self-checking testbench for the packed I/Q float decoder core.
module packed_iq_float_decode_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] i_code;
      logic [15:0] q_code;
      logic        last;
   } gate_in_type;

   typedef struct {
      logic [31:0] i_value;
      logic [31:0] q_value;
      logic        last;
   } gate_out_type;

   // Directed rows: has_exp marks rows whose result is typed in.
   typedef struct {
      logic        high_snr;
      logic [15:0] i_code;
      logic [15:0] q_code;
      logic        last;
      logic        has_exp;
      logic [31:0] i_exp;
      logic [31:0] q_exp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   logic         fmt_high_snr = 1'b0;
   gate_out_type pending_gates[$];
   int           mismatches = 0;
   bit           rx_hold = 1'b0;
   bit           no_idle = 1'b0;

   packed_iq_float_decode_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Pattern of m * 2^e as IEEE single; m is nonzero.
   function automatic logic [31:0] float_of(int m, int e);
      logic        sgn;
      int          mag;
      int          p;
      logic [31:0] frac;
      sgn = (m < 0);
      mag = sgn ? -m : m;
      p = 0;
      while (p < 31 && (mag >> (p + 1)) != 0) p++;
      frac = (32'(mag) << (23 - p)) & 32'h007F_FFFF;
      return {sgn, 8'(p + e + 127), frac[22:0]};
   endfunction

   function automatic logic [31:0] decode_code(logic [15:0] code, logic high_snr);
      int m;
      int ex;
      if (!high_snr) begin
         if (code == 16'h0) return 32'h0;
         ex = int'(code[15:11]);
         m = code[10] ? int'(code[9:0]) - 2048 : int'(code[9:0]) + 1024;
         return float_of(m, ex - 40);
      end
      ex = int'(code[15:12]);
      if (ex != 0) begin
         m = code[11] ? int'(code[10:0]) - 4096 : int'(code[10:0]) + 2048;
         return float_of(m, ex - 25);
      end
      m = code[11] ? int'(code[11:0]) - 4096 : int'(code[11:0]);
      if (m == 0) return 32'h0;
      return float_of(m, -24);
   endfunction

   function automatic gate_out_type decode_gate(gate_in_type g);
      gate_out_type r;
      r.i_value = decode_code(g.i_code, fmt_high_snr);
      r.q_value = decode_code(g.q_code, fmt_high_snr);
      r.last = g.last;
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("error: %s got %h expected %h", what, got, want);
      mismatches++;
   endtask

   // Result side: random stalls, plus a long hold-off when rx_hold is set.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      gate_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_gates.size() == 0) begin
            report("unexpected result", rsp_tdata, 64'h0);
         end else begin
            want = pending_gates.pop_front();
            if (rsp_tdata[31:0] !== want.i_value) report("i_value", rsp_tdata[31:0], want.i_value);
            if (rsp_tdata[63:32] !== want.q_value)
               report("q_value", rsp_tdata[63:32], want.q_value);
            if (rsp_tlast !== want.last) report("last_gate", rsp_tlast, want.last);
         end
      end
   end

   task automatic wait_drained();
      while (pending_gates.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_format(logic high_snr);
      // The last gate must not be offered again while the block drains.
      req_tvalid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= high_snr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fmt_high_snr = high_snr;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one gate; valid stays high across back-to-back items.
   task automatic send_gate(gate_in_type g, bit allow_gap);
      if (allow_gap && !no_idle) begin
         while ($urandom_range(99) < 6) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {g.q_code, g.i_code};
      req_tlast <= g.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_gates.insert(pending_gates.size(), decode_gate(g));
      @(negedge clock);
   endtask

   task automatic send_row(row_type r);
      gate_in_type g;
      gate_out_type want;
      g.i_code = r.i_code;
      g.q_code = r.q_code;
      g.last = r.last;
      if (r.has_exp) begin
         want = decode_gate(g);
         if (want.i_value !== r.i_exp) report("table i_value", want.i_value, r.i_exp);
         if (want.q_value !== r.q_exp) report("table q_value", want.q_value, r.q_exp);
      end
      send_gate(g, 1'b1);
   endtask

   function automatic logic [15:0] random_code();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(16'h0FFF));
         default: return 16'($urandom);
      endcase
   endfunction

   row_type stim_table[] = '{
      '{1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{1'b0, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{1'b0, 16'h0400, 16'h03FF, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b0, 16'hF800, 16'h07FF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b0, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{1'b1, 16'h0001, 16'h0FFF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'h0800, 16'h07FF, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'h1000, 16'h1800, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'hF000, 16'hFFFF, 1'b1, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'hF7FF, 16'h1FFF, 1'b0, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 32'h0, 32'h0},
      '{1'b1, 16'h8000, 16'h0FFF, 1'b0, 1'b0, 32'h0, 32'h0}
   };

   initial begin
      gate_in_type g;
      int          hold_len;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[k]) begin
         if (stim_table[k].high_snr !== fmt_high_snr) write_format(stim_table[k].high_snr);
         send_row(stim_table[k]);
      end
      req_tvalid <= 1'b0;
      write_format(1'b0);

      for (int n = 0; n < 550; n++) begin
         if (n % 110 == 0 && n != 0) begin
            req_tvalid <= 1'b0;
            write_format(1'($urandom_range(1)));
         end
         no_idle = (n >= 200 && n < 280);
         // Long receiver hold-off while the sender keeps offering gates.
         if (n == 300) begin
            hold_len = 40;
            fork
               begin
                  rx_hold = 1'b1;
                  repeat (hold_len) @(negedge clock);
                  rx_hold = 1'b0;
               end
            join_none
         end
         // Sender pauses until every expected result has come.
         if (n == 420) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         g.i_code = random_code();
         g.q_code = random_code();
         g.last = 1'($urandom_range(1));
         send_gate(g, 1'b1);
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (pending_gates.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("packed_iq_float_decode_core: match");
      end else begin
         $display("packed_iq_float_decode_core: mismatch");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("packed_iq_float_decode_core: mismatch");
      $finish;
   end

endmodule

@@ packed_iq_float_decode_core.f @@
sv/piqfd_pkg.sv
sv/piqfd_lane.sv
sv/piqfd_pack.sv
sv/packed_iq_float_decode_core.sv
dv/packed_iq_float_decode_core_test.sv
